>>> rtl/lrsp_pkg.sv
// ---------------------------------------------------------------------------
// lrsp_pkg: shared types and constants of the latency report parser
// Character codes, status codes, register indexes, reset values and the
// request/result/config structs used by the top level and the core.
// ---------------------------------------------------------------------------
package lrsp_pkg;

  localparam int DIGIT_SLOTS_DEF = 6;

  localparam logic [7:0] CHAR_NUL     = 8'd0;
  localparam logic [7:0] CHAR_LOW_A   = 8'd97;
  localparam logic [7:0] CHAR_LOW_Z   = 8'd122;
  localparam logic [7:0] CHAR_ZERO    = 8'd48;
  localparam logic [7:0] CHAR_NINE    = 8'd57;
  localparam logic [7:0] CHAR_START   = 8'd108;  // 'l'
  localparam logic [7:0] CHAR_MSEC    = 8'd109;  // 'm'
  localparam logic [7:0] CHAR_USEC    = 8'd117;  // 'u'
  localparam logic [7:0] CHAR_PONG    = 8'd98;   // 'b'

  localparam logic [31:0] MS_TO_US = 32'd1000;

  localparam logic [1:0] STATUS_READY  = 2'd0;
  localparam logic [1:0] STATUS_RESULT = 2'd1;
  localparam logic [1:0] STATUS_PING   = 2'd2;

  localparam logic [1:0] REG_AUDIO_MODE = 2'd0;
  localparam logic [1:0] REG_GAME_MODE  = 2'd1;
  localparam logic [1:0] REG_MIN_LAT    = 2'd2;
  localparam logic [1:0] REG_MAX_LAT    = 2'd3;

  localparam logic [31:0] MIN_LAT_RESET = 32'd1000;
  localparam logic [31:0] MAX_LAT_RESET = 32'd1000000;

  typedef struct packed {
    logic [7:0]  char_code;
    logic [31:0] timestamp_us;
    logic        link_up;
  } item_t;

  typedef struct packed {
    logic        send_ping;
    logic        start_playback;
    logic        mouse_click;
    logic        report_valid;
    logic [31:0] internal_us;
    logic [31:0] external_us;
    logic [31:0] ping_us;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic        audio_mode;
    logic        game_mode;
    logic [31:0] min_latency_us;
    logic [31:0] max_latency_us;
  } cfg_t;

endpackage

>>> rtl/lrsp_core.sv
// ---------------------------------------------------------------------------
// lrsp_core: parser state and next-state logic
// Holds the phase, the digit accumulators and the captured times, and
// works out the result of the request presented on req when fire is high.
// ---------------------------------------------------------------------------
module lrsp_core #(
  parameter int DIGIT_SLOTS = lrsp_pkg::DIGIT_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  lrsp_pkg::item_t  req,
  input  lrsp_pkg::cfg_t   cfg,
  output lrsp_pkg::result_t res
);
  import lrsp_pkg::*;

  localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);

  typedef enum logic [1:0] {
    PH_IDLE   = STATUS_READY,
    PH_RESULT = STATUS_RESULT,
    PH_PING   = STATUS_PING
  } phase_t;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] digit_count, digit_count_next;
  // Horner accumulators of the digits so far, in plain units and times 1000
  logic [31:0]      acc, acc_next;
  logic [31:0]      acc_ms, acc_ms_next;
  logic [31:0]      start_time, start_time_next;
  logic [31:0]      first_reply_time, first_reply_time_next;
  logic [31:0]      ping_start_time, ping_start_time_next;
  logic [31:0]      internal_latency, internal_latency_next;
  logic [31:0]      external_latency, external_latency_next;

  logic        active, alnum, first_char, fail;
  logic [7:0]  digit;
  logic [31:0] digit_ms, reply_time, intl, ext;
  phase_t      ph_eff;

  always_comb begin
    phase_next            = phase;
    digit_count_next      = digit_count;
    acc_next              = acc;
    acc_ms_next           = acc_ms;
    start_time_next       = start_time;
    first_reply_time_next = first_reply_time;
    ping_start_time_next  = ping_start_time;
    internal_latency_next = internal_latency;
    external_latency_next = external_latency;
    res                   = '0;

    active = (req.char_code != CHAR_NUL) && req.link_up;
    alnum  = ((req.char_code >= CHAR_LOW_A) && (req.char_code <= CHAR_LOW_Z)) ||
             ((req.char_code >= CHAR_ZERO) && (req.char_code <= CHAR_NINE));
    ph_eff     = alnum ? phase : PH_IDLE;
    first_char = (digit_count == '0);
    digit      = req.char_code - CHAR_ZERO;
    digit_ms   = {14'd0, {digit, 10'd0} - {6'd0, digit, 4'd0} - {7'd0, digit, 3'd0}};
    reply_time = first_char ? req.timestamp_us : first_reply_time;
    intl       = reply_time - start_time;
    ext        = (req.char_code == CHAR_MSEC) ? acc_ms : acc;
    fail       = (ext > cfg.max_latency_us) || (intl > cfg.max_latency_us) ||
                 (ext < cfg.min_latency_us) || (intl < cfg.min_latency_us);

    if (active) begin
      if (!alnum) begin
        internal_latency_next = '0;
        external_latency_next = '0;
        phase_next            = PH_IDLE;
      end
      unique case (ph_eff)
        PH_IDLE: begin
          if (req.char_code == CHAR_START) begin
            start_time_next    = req.timestamp_us;
            phase_next         = PH_RESULT;
            res.start_playback = cfg.audio_mode;
            res.mouse_click    = cfg.game_mode;
          end
        end
        PH_RESULT: begin
          if (first_char) first_reply_time_next = req.timestamp_us;
          if ((req.char_code == CHAR_MSEC) || (req.char_code == CHAR_USEC)) begin
            internal_latency_next = intl;
            external_latency_next = ext;
            digit_count_next      = '0;
            acc_next              = '0;
            acc_ms_next           = '0;
            if (fail) begin
              phase_next = PH_IDLE;
            end else begin
              res.send_ping        = 1'b1;
              ping_start_time_next = req.timestamp_us;
              phase_next           = PH_PING;
            end
          end else if (digit_count < CNT_W'(DIGIT_SLOTS)) begin
            acc_next         = {acc[28:0], 3'd0} + {acc[30:0], 1'd0} + {24'd0, digit};
            acc_ms_next      = {acc_ms[28:0], 3'd0} + {acc_ms[30:0], 1'd0} + digit_ms;
            digit_count_next = digit_count + CNT_W'(1);
          end
        end
        PH_PING: begin
          if (req.char_code == CHAR_PONG) begin
            res.report_valid = 1'b1;
            res.internal_us  = internal_latency;
            res.external_us  = external_latency;
            res.ping_us      = req.timestamp_us - ping_start_time;
            phase_next       = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
    res.status = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      digit_count      <= '0;
      acc              <= '0;
      acc_ms           <= '0;
      start_time       <= '0;
      first_reply_time <= '0;
      ping_start_time  <= '0;
      internal_latency <= '0;
      external_latency <= '0;
    end else if (fire) begin
      phase            <= phase_next;
      digit_count      <= digit_count_next;
      acc              <= acc_next;
      acc_ms           <= acc_ms_next;
      start_time       <= start_time_next;
      first_reply_time <= first_reply_time_next;
      ping_start_time  <= ping_start_time_next;
      internal_latency <= internal_latency_next;
      external_latency <= external_latency_next;
    end
  end

  // the ms accumulator always tracks the plain one times 1000
  a_acc_ms: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (acc_ms == 32'(acc * MS_TO_US))) else $error("ms accumulator out of step");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (digit_count <= CNT_W'(DIGIT_SLOTS))) else $error("digit count overflow");

  a_clear_on_close: assert property (@(posedge clk) disable iff (rst)
    (fire && res.send_ping) |=> (digit_count == '0) && (acc == '0))
    else $error("digits not cleared on close");

endmodule

>>> rtl/latency_report_serial_parser.sv
// ---------------------------------------------------------------------------
// latency_report_serial_parser: serial latency device report parser
// Input register, parser core and result register, one character a cycle unless the result is stalled.
// ---------------------------------------------------------------------------
//  channel | signals                          | direction
//  --------+----------------------------------+-----------
//  in      | in_valid, in_stall, char fields  | request in
//  out     | out_valid, out_stall, results    | result out
//  cfg     | cfg_en, cfg_index, cfg_data      | write only
//
// One result per request; out_valid rises once the request has passed the
// input register and the result register. A new request is taken every cycle while in_stall is low.
// Reset clears the phase, accumulators, times and config to defaults.
// A stalled result holds; the input register still takes one request
// while it is empty, then in_stall rises.
module latency_report_serial_parser #(
  parameter int DIGIT_SLOTS = lrsp_pkg::DIGIT_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic [31:0] timestamp_us,
  input  logic        link_up,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        send_ping,
  output logic        start_playback,
  output logic        mouse_click,
  output logic        report_valid,
  output logic [31:0] internal_us,
  output logic [31:0] external_us,
  output logic [31:0] ping_us,
  output logic [1:0]  status,
  input  logic        cfg_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import lrsp_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  result_t res, out_res;
  logic    advance, fire;

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.audio_mode     <= 1'b0;
      cfg.game_mode      <= 1'b0;
      cfg.min_latency_us <= MIN_LAT_RESET;
      cfg.max_latency_us <= MAX_LAT_RESET;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_AUDIO_MODE: cfg.audio_mode     <= cfg_data[0];
        REG_GAME_MODE:  cfg.game_mode      <= cfg_data[0];
        REG_MIN_LAT:    cfg.min_latency_us <= cfg_data;
        REG_MAX_LAT:    cfg.max_latency_us <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_item <= '{char_code: char_code, timestamp_us: timestamp_us, link_up: link_up};
    end
  end

  lrsp_core #(
    .DIGIT_SLOTS(DIGIT_SLOTS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .fire(fire),
    .req (s1_item),
    .cfg (cfg),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (fire) out_res <= res;
  end

  assign send_ping      = out_res.send_ping;
  assign start_playback = out_res.start_playback;
  assign mouse_click    = out_res.mouse_click;
  assign report_valid   = out_res.report_valid;
  assign internal_us    = out_res.internal_us;
  assign external_us    = out_res.external_us;
  assign ping_us        = out_res.ping_us;
  assign status         = out_res.status;

  a_report_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && report_valid) |-> (status == STATUS_READY))
    else $error("report without return to idle");

  a_ping_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && send_ping) |-> (status == STATUS_PING))
    else $error("ping request outside ping wait");

  a_strobe_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (start_playback || mouse_click)) |-> (status == STATUS_RESULT))
    else $error("start strobe outside result wait");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !report_valid) |->
      ((internal_us == '0) && (external_us == '0) && (ping_us == '0)))
    else $error("report fields set without report");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid)) else $error("pipeline not empty after reset");

endmodule

>>> tb/latency_report_serial_parser_tb.sv
// ---------------------------------------------------------------------------
// latency_report_serial_parser_tb: self-checking bench for the report parser
// Drives serial characters with timestamps through the request channel and
// predicts every result: start strobes, ping request, latency report and
// parser status. Results are compared field by field, in order. A directed
// stream covers the corner cases; random measurement sequences run under
// several limit and mode settings, with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module latency_report_serial_parser_tb;
  import lrsp_pkg::*;

  localparam int SLOTS       = DIGIT_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code    = 8'd0;
  logic [31:0] timestamp_us = 32'd0;
  logic        link_up      = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic        send_ping;
  logic        start_playback;
  logic        mouse_click;
  logic        report_valid;
  logic [31:0] internal_us;
  logic [31:0] external_us;
  logic [31:0] ping_us;
  logic [1:0]  status;
  logic        cfg_en       = 1'b0;
  logic [1:0]  cfg_index    = REG_AUDIO_MODE;
  logic [31:0] cfg_data     = 32'd0;

  // predictor copy of the configuration and parser state
  logic        cfg_audio    = 1'b0;
  logic        cfg_game     = 1'b0;
  logic [31:0] cfg_min_us   = MIN_LAT_RESET;
  logic [31:0] cfg_max_us   = MAX_LAT_RESET;
  logic [1:0]  parse_phase  = STATUS_READY;
  int          digit_count  = 0;
  logic [7:0]  digit_store [SLOTS] = '{default: 8'd0};
  logic [31:0] start_time   = 32'd0;
  logic [31:0] first_reply  = 32'd0;
  logic [31:0] ping_start   = 32'd0;
  logic [31:0] internal_lat = 32'd0;
  logic [31:0] external_lat = 32'd0;

  result_t     pending_parse_q [$];
  result_t     want;
  int          mismatches   = 0;
  int          parsed_count = 0;
  int          stall_left   = 0;
  int          cycle_count  = 0;
  logic        idle_en      = 1'b1;
  logic [31:0] clock_us;

  latency_report_serial_parser uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .timestamp_us   (timestamp_us),
    .link_up        (link_up),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .send_ping      (send_ping),
    .start_playback (start_playback),
    .mouse_click    (mouse_click),
    .report_valid   (report_valid),
    .internal_us    (internal_us),
    .external_us    (external_us),
    .ping_us        (ping_us),
    .status         (status),
    .cfg_en         (cfg_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Advances the parser model by one character and returns its outputs.
  function automatic result_t parse_char(input logic [7:0] code, input logic [31:0] ts,
                                         input logic link_state);
    result_t     r;
    logic [31:0] num;
    logic [31:0] hi;
    logic [31:0] lo;
    int          i;
    r = '0;
    if (code != CHAR_NUL && link_state) begin
      if (!((code >= CHAR_LOW_A && code <= CHAR_LOW_Z) ||
            (code >= CHAR_ZERO && code <= CHAR_NINE))) begin
        internal_lat = 32'd0;
        external_lat = 32'd0;
        parse_phase  = STATUS_READY;
      end
      case (parse_phase)
        STATUS_READY: begin
          if (code == CHAR_START) begin
            start_time       = ts;
            parse_phase      = STATUS_RESULT;
            r.start_playback = cfg_audio;
            r.mouse_click    = cfg_game;
          end
        end
        STATUS_RESULT: begin
          // reply time only latches while no digit is held, even stale ones
          if (digit_count == 0) first_reply = ts;
          if (code == CHAR_MSEC || code == CHAR_USEC) begin
            num = 32'd0;
            for (i = 0; i < digit_count; i++) num = num * 32'd10 + 32'(digit_store[i]);
            internal_lat = first_reply - start_time;
            digit_count  = 0;
            digit_store  = '{default: 8'd0};
            if (code == CHAR_MSEC) num = num * MS_TO_US;
            external_lat = num;
            hi = (num > internal_lat) ? num : internal_lat;
            lo = (num < internal_lat) ? num : internal_lat;
            if (hi > cfg_max_us || lo < cfg_min_us) begin
              parse_phase = STATUS_READY;
            end else begin
              r.send_ping = 1'b1;
              ping_start  = ts;
              parse_phase = STATUS_PING;
            end
          end else if (digit_count < SLOTS) begin
            digit_store[digit_count] = code - CHAR_ZERO;
            digit_count++;
          end
        end
        STATUS_PING: begin
          if (code == CHAR_PONG) begin
            r.report_valid = 1'b1;
            r.internal_us  = internal_lat;
            r.external_us  = external_lat;
            r.ping_us      = ts - ping_start;
            parse_phase    = STATUS_READY;
          end
        end
        default: ;
      endcase
    end
    r.status = parse_phase;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_parse_q.size() == 0) begin
          $error("result with no request pending");
          mismatches++;
        end else begin
          want = pending_parse_q.pop_front();
          check_field("send_ping", want.send_ping, send_ping);
          check_field("start_playback", want.start_playback, start_playback);
          check_field("mouse_click", want.mouse_click, mouse_click);
          check_field("report_valid", want.report_valid, report_valid);
          check_field("internal_us", want.internal_us, internal_us);
          check_field("external_us", want.external_us, external_us);
          check_field("ping_us", want.ping_us, ping_us);
          check_field("status", want.status, status);
        end
        stall_left = idle_en ? $urandom_range(0, 16) : 0;
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0 && out_valid) stall_left--;
    end
  end

  // Leaves in_valid high on return so back-to-back requests need no extra NBA.
  task automatic send_char(input logic [7:0] code, input logic [31:0] ts,
                           input logic link_state);
    int gap;
    gap = idle_en ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    char_code    <= code;
    timestamp_us <= ts;
    link_up      <= link_state;
    do @(posedge clk); while (in_stall);
    pending_parse_q.push_back(parse_char(code, ts, link_state));
    if (code != CHAR_NUL && link_state) parsed_count++;
  endtask

  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (pending_parse_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic audio, input logic game, input logic [31:0] min_us,
                            input logic [31:0] max_us);
    wait_for_quiet();
    cfg_en    <= 1'b1;
    cfg_index <= REG_AUDIO_MODE;
    cfg_data  <= {31'd0, audio};
    @(posedge clk);
    cfg_audio = audio;
    cfg_index <= REG_GAME_MODE;
    cfg_data  <= {31'd0, game};
    @(posedge clk);
    cfg_game = game;
    cfg_index <= REG_MIN_LAT;
    cfg_data  <= min_us;
    @(posedge clk);
    cfg_min_us = min_us;
    cfg_index <= REG_MAX_LAT;
    cfg_data  <= max_us;
    @(posedge clk);
    cfg_max_us = max_us;
    cfg_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_ignored_char();
    if ($urandom_range(0, 1) != 0) send_char(CHAR_NUL, $urandom, 1'b1);
    else send_char(8'($urandom_range(0, 255)), $urandom, 1'b0);
  endtask

  // One start/reply/ping exchange with random content; sometimes broken off.
  task automatic run_measurement();
    logic [31:0] lat;
    logic [31:0] ext_val;
    logic [31:0] span;
    logic [7:0]  pick;
    logic [7:0]  digit_chars [$];
    logic        use_ms;
    int          k;
    span = 32'd0;
    if (cfg_max_us >= cfg_min_us)
      span = (cfg_max_us - cfg_min_us > 32'd2000000) ? 32'd2000000 : cfg_max_us - cfg_min_us;
    case ($urandom_range(0, 9))
      0:       lat = $urandom;
      1:       lat = cfg_min_us - $urandom_range(0, 2);
      2:       lat = cfg_max_us + 32'd1 - $urandom_range(0, 2);
      default: lat = cfg_min_us + $urandom_range(0, span);
    endcase
    use_ms = ($urandom_range(0, 3) == 0);
    if (use_ms) ext_val = lat / 32'd1000 + $urandom_range(0, 2) - 32'd1;
    else ext_val = lat + $urandom_range(0, 20) - 32'd10;
    ext_val = ext_val % 32'd1000000;

    digit_chars = {};
    if (ext_val == 0) digit_chars.push_back(CHAR_ZERO);
    while (ext_val != 0) begin
      digit_chars.push_front(CHAR_ZERO + 8'(ext_val % 32'd10));
      ext_val = ext_val / 32'd10;
    end
    if ($urandom_range(0, 7) == 0) digit_chars.push_front(CHAR_ZERO);
    if ($urandom_range(0, 11) == 0)
      repeat ($urandom_range(1, 3)) digit_chars.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
    if ($urandom_range(0, 9) == 0) begin
      do pick = 8'($urandom_range(CHAR_LOW_A, CHAR_LOW_Z));
      while (pick == CHAR_MSEC || pick == CHAR_USEC);
      digit_chars[$urandom_range(0, digit_chars.size() - 1)] = pick;
    end
    if ($urandom_range(0, 24) == 0) digit_chars = {};

    clock_us += $urandom_range(1, 5000);
    send_char(CHAR_START, clock_us, 1'b1);
    clock_us += lat;
    for (k = 0; k < digit_chars.size(); k++) begin
      if ($urandom_range(0, 19) == 0) send_ignored_char();
      if ($urandom_range(0, 39) == 0) begin
        do pick = 8'($urandom_range(1, 255));
        while ((pick >= CHAR_LOW_A && pick <= CHAR_LOW_Z) ||
               (pick >= CHAR_ZERO && pick <= CHAR_NINE));
        send_char(pick, clock_us, 1'b1);
        return;
      end
      send_char(digit_chars[k], clock_us, 1'b1);
      clock_us += $urandom_range(50, 3000);
    end
    if ($urandom_range(0, 24) == 0) return;
    send_char(use_ms ? CHAR_MSEC : CHAR_USEC, clock_us, 1'b1);

    if ($urandom_range(0, 4) == 0) begin
      do pick = 8'($urandom_range(CHAR_LOW_A, CHAR_LOW_Z));
      while (pick == CHAR_PONG);
      clock_us += $urandom_range(0, 5000);
      send_char(pick, clock_us, 1'b1);
    end
    clock_us += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 200000);
    send_char(CHAR_PONG, clock_us, 1'b1);
  endtask

  task automatic run_random(input int count);
    int target;
    target = parsed_count + count;
    while (parsed_count < target) begin
      if ($urandom_range(0, 7) == 0) idle_en = ~idle_en;
      if ($urandom_range(0, 39) == 0) wait_for_quiet();
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          clock_us += $urandom_range(0, 100000);
          send_char(8'($urandom_range(0, 255)), clock_us, $urandom_range(0, 7) != 0);
        end
      end else begin
        run_measurement();
      end
    end
  endtask

  // Reset values of the limits and modes, never written yet.
  task automatic test_reset_limits();
    run_random(260);
  endtask

  task automatic test_directed_chars();
    set_config(1'b1, 1'b1, 32'd0, 32'hFFFF_FFFF);
    idle_en = 1'b1;
    send_char(CHAR_NUL, 32'h1234_5678, 1'b1);
    send_char(CHAR_START, 32'h0000_0010, 1'b0);
    send_char(CHAR_START, 32'hFFFF_FF00, 1'b1);     // both strobes
    send_char("z", 32'h0000_0100, 1'b1);            // first reply, time wraps
    send_char("z", 32'h0000_0180, 1'b1);
    send_char("9", 32'h0000_0200, 1'b1);
    send_char("9", 32'h0000_0280, 1'b1);
    send_char("a", 32'h0000_0300, 1'b1);
    send_char("5", 32'h0000_0380, 1'b1);
    send_char("3", 32'h0000_0400, 1'b1);            // slots full, dropped
    send_char(CHAR_MSEC, 32'h0000_1000, 1'b1);      // ms scaling wraps
    send_char("x", 32'h0000_2000, 1'b1);            // ignored while pinging
    send_char(CHAR_PONG, 32'hFFFF_FFFF, 1'b1);
    send_char(CHAR_START, 32'h0000_0100, 1'b1);
    send_char("7", 32'h0000_0300, 1'b1);
    send_char(8'hFF, 32'h0000_0350, 1'b1);          // abort keeps the digit
    send_char(CHAR_START, 32'h0000_0400, 1'b1);
    send_char("4", 32'h0000_0900, 1'b1);            // stale reply time
    send_char(CHAR_USEC, 32'h0000_0A00, 1'b1);
    send_char(8'h2F, 32'h0000_0B00, 1'b1);          // abort from ping wait
    send_char("q", 32'h0000_0C00, 1'b1);
    send_char(8'h80, 32'h0000_0D00, 1'b1);
    send_char(CHAR_USEC, 32'h0000_0E00, 1'b1);
    send_char(CHAR_PONG, 32'h0000_0F00, 1'b1);
    send_char(CHAR_START, 32'h0000_1000, 1'b1);
    send_char(CHAR_MSEC, 32'h0000_1400, 1'b1);      // no digits at all
    send_char(CHAR_PONG, 32'h0000_2400, 1'b1);
  endtask

  task automatic test_limit_sweep();
    set_config(1'b1, 1'b0, 32'd2000, 32'd200000);
    run_random(170);
    set_config(1'b0, 1'b1, 32'd0, 32'hFFFF_FFFF);
    run_random(170);
    set_config(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(170);
    set_config(1'b0, 1'b0, 32'd0, 32'd0);
    run_random(170);
    set_config(1'b1, 1'b1, 32'd500, 32'd5000000);
    run_random(170);
  endtask

  initial begin
    clock_us = $urandom;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_limits();
    test_directed_chars();
    test_limit_sweep();
    wait_for_quiet();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_parse_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lrsp_pkg.sv
rtl/lrsp_core.sv
rtl/latency_report_serial_parser.sv
tb/latency_report_serial_parser_tb.sv
